@@ hw/rtl/lpht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int NBUCKETS    = 512;
    localparam int CAPACITY    = 256;
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_BYTES = 8;

    localparam int BIDX_W = $clog2(NBUCKETS);
    localparam int SLOT_W = $clog2(CAPACITY + 1);
    localparam int EIDX_W = $clog2(CAPACITY);
    localparam int BCNT_W = 10;
    localparam int ICAP_W = 9;
    localparam int NBYT_W = 4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NO_BUCKET = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [1:0] REG_BUCKET_COUNT  = 2'd0;
    localparam logic [1:0] REG_ITEM_CAPACITY = 2'd1;
    localparam logic [1:0] REG_KEY_BYTES     = 2'd2;
    localparam logic [1:0] REG_VALUE_BYTES   = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_MOD, S_READ, S_CHECK, S_ENTRY, S_COMPARE, S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic hash_step;
        logic mod_step;
        logic probe_start;
        logic bucket_rd;
        logic entry_rd;
        logic advance;
        logic commit;
        logic finish;
        logic [1:0] status;
        logic       found;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hash_last;
        logic mod_last;
        logic is_lookup;
        logic store_full;
        logic slot_empty;
        logic key_match;
        logic wrap_home;
    } sts_t;

    function automatic logic [63:0] byte_mask(input logic [NBYT_W-1:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < int'(n)) m[i*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/linear_probe_hash_table_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Hash table with linear probing over a 512-bucket table and 256 entries.
//
// channel  direction  content
// s_       in         tdata: mode[0], key[64:1], value[128:65]
// m_       out        tdata: status[1:0], found_value[65:2]
// cfg_     in         index 0..3, data
//
// Steps: hash over the key bytes, modulo, then a bucket read per bucket probed,
// with an entry read per occupied bucket on lookup, a bucket write on a stored
// insert and a hand-off. A store-full insert skips probing. After reset a pass over
// all buckets clears the bucket table; no request is taken. A result waits in a
// result register until the output register is free; the next request is taken once it has moved there.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,   // mode, key, value, pad
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata,   // status, found_value, pad
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import lpht_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic out_busy;

    assign cfg_ready = 1'b1;

    lpht_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .out_busy, .sts, .cmd
    );

    lpht_dp u_dp (
        .aclk, .aresetn, .cfg_valid, .cfg_index, .cfg_data,
        .s_tdata(s_tdata[128:0]), .cmd, .sts, .out_busy,
        .m_tvalid, .m_tready, .m_tdata
    );

endmodule
`default_nettype wire

@@ hw/rtl/lpht_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: bucket clear, hash, modulo, probe loop and result hand-off.
// ----------------------------------------------------------------------------
module lpht_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic           out_busy,
    input  wire lpht_pkg::sts_t sts,
    output lpht_pkg::cmd_t      cmd
);
    import lpht_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_CLEAR;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last) state_next = S_MOD;
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last) begin
                    if (!sts.is_lookup && sts.store_full) begin
                        cmd.status = ST_FULL;
                        state_next = S_DONE;
                    end else begin
                        cmd.probe_start = 1'b1;
                        state_next      = S_READ;
                    end
                end
            end
            S_READ: begin
                cmd.bucket_rd = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK: begin
                if (sts.slot_empty) begin
                    if (sts.is_lookup) begin
                        cmd.status = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_WRITE;
                    end
                end else if (sts.is_lookup) begin
                    cmd.entry_rd = 1'b1;
                    state_next   = S_ENTRY;
                end else begin
                    cmd.advance = 1'b1;
                    if (sts.wrap_home) begin
                        cmd.status = ST_NO_BUCKET;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_ENTRY: state_next = S_COMPARE;
            S_COMPARE: begin
                if (sts.key_match) begin
                    cmd.status = ST_OK;
                    cmd.found  = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.advance = 1'b1;
                    if (sts.wrap_home) begin
                        cmd.status = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_WRITE: begin
                cmd.commit = 1'b1;
                cmd.status = ST_OK;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/lpht_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: config registers, hash, restoring modulo, bucket and entry
// memories, output register.
// ----------------------------------------------------------------------------
module lpht_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [31:0]                   cfg_data,
    input  wire logic [128:0]                  s_tdata,
    input  wire lpht_pkg::cmd_t                cmd,
    output lpht_pkg::sts_t                     sts,
    output logic                               out_busy,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [71:0]                        m_tdata
);
    import lpht_pkg::*;

    logic [BCNT_W-1:0] bcnt_reg;
    logic [ICAP_W-1:0] icap_reg;
    logic [NBYT_W-1:0] kbyt_reg, vbyt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcnt_reg <= BCNT_W'(NBUCKETS);
            icap_reg <= ICAP_W'(CAPACITY);
            kbyt_reg <= NBYT_W'(KEY_BYTES);
            vbyt_reg <= NBYT_W'(VALUE_BYTES);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BUCKET_COUNT:  bcnt_reg <= cfg_data[BCNT_W-1:0];
                REG_ITEM_CAPACITY: icap_reg <= cfg_data[ICAP_W-1:0];
                REG_KEY_BYTES:     kbyt_reg <= cfg_data[NBYT_W-1:0];
                REG_VALUE_BYTES:   vbyt_reg <= cfg_data[NBYT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [BCNT_W-1:0] nb;
    logic [ICAP_W-1:0] cap;
    logic [NBYT_W-1:0] nkb, nvb;
    always_comb begin
        nb  = (bcnt_reg == '0) ? BCNT_W'(1)
            : (bcnt_reg > BCNT_W'(NBUCKETS)) ? BCNT_W'(NBUCKETS) : bcnt_reg;
        cap = (icap_reg > ICAP_W'(CAPACITY)) ? ICAP_W'(CAPACITY) : icap_reg;
        nkb = (kbyt_reg == '0) ? NBYT_W'(1)
            : (kbyt_reg > NBYT_W'(KEY_BYTES)) ? NBYT_W'(KEY_BYTES) : kbyt_reg;
        nvb = (vbyt_reg == '0) ? NBYT_W'(1)
            : (vbyt_reg > NBYT_W'(VALUE_BYTES)) ? NBYT_W'(VALUE_BYTES) : vbyt_reg;
    end

    logic              mode_reg;
    logic [63:0]       key_reg, val_reg;
    logic [31:0]       hash_reg;
    logic [3:0]        hcnt_reg;
    logic [5:0]        mcnt_reg;
    logic [BCNT_W-1:0] rem_reg;
    logic [BIDX_W-1:0] home_reg, bptr_reg, clr_reg;
    logic [SLOT_W-1:0] slot_reg, ecount_reg;
    logic [63:0]       ekey_reg, eval_reg;
    logic [SLOT_W-1:0] bucket_mem [NBUCKETS];
    logic [63:0]       ekey_mem [CAPACITY];
    logic [63:0]       eval_mem [CAPACITY];

    logic [7:0]        hbyte;
    logic [BCNT_W:0]   rtrial;
    logic [BIDX_W:0]   bnext;
    logic [63:0]       kmask, vmask;
    logic [BCNT_W-1:0] rem_final;

    assign kmask  = byte_mask(nkb);
    assign vmask  = byte_mask(nvb);
    assign hbyte  = key_reg[hcnt_reg[2:0]*8 +: 8];
    assign rtrial = {rem_reg, hash_reg[31]} - {1'b0, nb};
    assign bnext  = ({1'b0, bptr_reg} + 1'b1 == (BIDX_W+1)'(nb)) ? '0
                  : {1'b0, bptr_reg} + 1'b1;
    assign rem_final = rtrial[BCNT_W] ? {rem_reg[BCNT_W-2:0], hash_reg[31]}
                                      : rtrial[BCNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ecount_reg <= '0;
            clr_reg    <= '0;
        end else begin
            if (cmd.clear_step) clr_reg <= clr_reg + 1'b1;
            if (cmd.commit)     ecount_reg <= ecount_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_tdata[0];
            key_reg  <= s_tdata[64:1] & kmask;
            val_reg  <= s_tdata[128:65] & vmask;
            hash_reg <= '0;
            hcnt_reg <= '0;
        end
        if (cmd.hash_step) begin
            hash_reg <= (hash_reg << 5) - hash_reg + {{24{hbyte[7]}}, hbyte};
            hcnt_reg <= hcnt_reg + 1'b1;
            mcnt_reg <= '0;
            rem_reg  <= '0;
        end
        if (cmd.mod_step) begin
            rem_reg  <= rem_final;
            hash_reg <= hash_reg << 1;
            mcnt_reg <= mcnt_reg + 1'b1;
        end
        if (cmd.probe_start) begin
            home_reg <= rem_final[BIDX_W-1:0];
            bptr_reg <= rem_final[BIDX_W-1:0];
        end
        if (cmd.advance) bptr_reg <= bnext[BIDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_step)    bucket_mem[clr_reg] <= '0;
        else if (cmd.commit)   bucket_mem[bptr_reg] <= ecount_reg + 1'b1;
        if (cmd.bucket_rd)     slot_reg <= bucket_mem[bptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            ekey_mem[ecount_reg[EIDX_W-1:0]] <= key_reg;
            eval_mem[ecount_reg[EIDX_W-1:0]] <= val_reg;
        end
        if (cmd.entry_rd) begin
            ekey_reg <= ekey_mem[EIDX_W'(slot_reg - 1'b1)];
            eval_reg <= eval_mem[EIDX_W'(slot_reg - 1'b1)];
        end
    end

    always_comb begin
        sts.clear_last = (clr_reg == BIDX_W'(NBUCKETS - 1));
        sts.hash_last  = (hcnt_reg + 1'b1 == nkb);
        sts.mod_last   = (mcnt_reg == 6'd31);
        sts.is_lookup  = mode_reg;
        sts.store_full = (ecount_reg >= SLOT_W'(cap));
        sts.slot_empty = (slot_reg == '0);
        sts.key_match  = ((ekey_reg & kmask) == key_reg);
        sts.wrap_home  = (bnext[BIDX_W-1:0] == home_reg);
    end

    logic cmd_end;
    assign cmd_end  = cmd.commit || (cmd.status != ST_OK) || cmd.found
                   || (cmd.mod_step && sts.mod_last && !mode_reg && sts.store_full);
    assign out_busy = m_tvalid && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid <= 1'b0;
        else if (cmd.finish) m_tvalid <= 1'b1;
        else if (m_tready)   m_tvalid <= 1'b0;
    end

    logic [1:0]  rstat_reg;
    logic [63:0] rval_reg;
    always_ff @(posedge aclk) begin
        if (cmd_end) begin
            rstat_reg <= cmd.status;
            rval_reg  <= cmd.found ? (eval_reg & vmask) : '0;
        end
        if (cmd.finish) m_tdata <= {6'd0, rval_reg, rstat_reg};
    end

endmodule
`default_nettype wire

@@ tb/linear_probe_hash_table_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top_tb
// Self-checking bench for the linear probing hash table. Inserts and lookups
// are predicted by a behavioural table model in a small scoreboard class and
// compared field by field against every response, over several register
// settings and with random stalls on both channels.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top_tb;
    import lpht_pkg::*;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;
    localparam int   WATCHDOG    = 200000;

    class table_scoreboard;
        int unsigned    nb, cap, nkb, nvb;
        int unsigned    slots [NBUCKETS];
        logic [63:0]    keys  [CAPACITY];
        logic [63:0]    vals  [CAPACITY];
        int unsigned    count;
        logic [1:0]     exp_status [$];
        logic [63:0]    exp_value  [$];
        int             errors;
        int             n_hits, n_miss, n_full, n_nobkt;

        function new();
            nb = NBUCKETS; cap = CAPACITY; nkb = KEY_BYTES; nvb = VALUE_BYTES;
            foreach (slots[i]) slots[i] = 0;
            count = 0; errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] d);
            int unsigned v;
            case (idx)
                REG_BUCKET_COUNT: begin
                    v = d[9:0];
                    nb = (v < 1) ? 1 : (v > NBUCKETS) ? NBUCKETS : v;
                end
                REG_ITEM_CAPACITY: begin
                    v = d[8:0];
                    cap = (v > CAPACITY) ? CAPACITY : v;
                end
                REG_KEY_BYTES: begin
                    v = d[3:0];
                    nkb = (v < 1) ? 1 : (v > KEY_BYTES) ? KEY_BYTES : v;
                end
                default: begin
                    v = d[3:0];
                    nvb = (v < 1) ? 1 : (v > VALUE_BYTES) ? VALUE_BYTES : v;
                end
            endcase
        endfunction

        function logic [63:0] mask_of(int unsigned n);
            return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        endfunction

        function void note_request(logic mode, logic [63:0] key_in, logic [63:0] val_in);
            logic [63:0] km, vm, key;
            logic [31:0] h, bb;
            int unsigned home, b;
            logic [1:0]  st;
            logic [63:0] fv;
            bit          full;
            km = mask_of(nkb); vm = mask_of(nvb);
            key = key_in & km;
            h = 0;
            for (int i = 0; i < nkb; i++) begin
                bb = {{24{key[8*i+7]}}, key[8*i +: 8]};
                h = h * 32'd31 + bb;
            end
            home = h % nb;
            b = home; st = ST_OK; fv = '0; full = 0;
            if (mode == MODE_INSERT) begin
                if (count >= cap) begin
                    st = ST_FULL;
                end else begin
                    while (slots[b] != 0) begin
                        b = (b + 1) % nb;
                        if (b == home) begin
                            full = 1;
                            break;
                        end
                    end
                    if (full) begin
                        st = ST_NO_BUCKET;
                    end else begin
                        slots[b] = count + 1;
                        keys[count] = key;
                        vals[count] = val_in & vm;
                        count++;
                    end
                end
            end else begin
                st = ST_NOT_FOUND;
                forever begin
                    if (slots[b] == 0) break;
                    if ((keys[slots[b]-1] & km) == key) begin
                        st = ST_OK;
                        fv = vals[slots[b]-1] & vm;
                        break;
                    end
                    b = (b + 1) % nb;
                    if (b == home) break;
                end
            end
            case (st)
                ST_OK:        if (mode == MODE_LOOKUP) n_hits++;
                ST_FULL:      n_full++;
                ST_NO_BUCKET: n_nobkt++;
                default:      n_miss++;
            endcase
            exp_status.push_back(st);
            exp_value.push_back(fv);
        endfunction

        function void check_response(logic [1:0] st, logic [63:0] fv);
            logic [1:0]  es;
            logic [63:0] ev;
            if (exp_status.size() == 0) begin
                $display("%0t: unexpected response status %0d value %h", $time, st, fv);
                errors++;
                return;
            end
            es = exp_status.pop_front();
            ev = exp_value.pop_front();
            if (st !== es) begin
                $display("%0t: status expected %0d actual %0d", $time, es, st);
                errors++;
            end
            if (fv !== ev) begin
                $display("%0t: found_value expected %h actual %h", $time, ev, fv);
                errors++;
            end
        endfunction
    endclass

    logic         aclk, aresetn;
    logic         s_tvalid, s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid, m_tready;
    logic [71:0]  m_tdata;
    logic         cfg_valid, cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    table_scoreboard sb;
    int src_idle, dst_idle;
    int quiet;
    int n_req;
    logic [63:0] key_pool [$];

    linear_probe_hash_table_top i_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // receiver, stalls and response check
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_response(m_tdata[1:0], m_tdata[65:2]);
    end
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= dst_idle);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
            !aresetn)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] d);
        @(negedge aclk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, d);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        while (sb.exp_status.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send(logic mode, logic [63:0] key, logic [63:0] val);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle) @(negedge aclk);
        s_tvalid <= 1;
        s_tdata  <= {7'd0, val, key, mode};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(mode, key, val);
        n_req++;
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(int n);
        logic [63:0] k;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                k = ($urandom_range(3) == 0) ? {56'd0, 8'($urandom_range(15))} : rand64();
                key_pool.push_back(k);
                send(MODE_INSERT, k, rand64());
            end else if (r < 85 && key_pool.size() != 0) begin
                send(MODE_LOOKUP, key_pool[$urandom_range(key_pool.size() - 1)], rand64());
            end else begin
                send(MODE_LOOKUP, rand64(), rand64());
            end
        end
    endtask

    initial begin
        sb = new();
        aresetn = 0; s_tvalid = 0; s_tdata = '0;
        cfg_valid = 0; cfg_index = REG_BUCKET_COUNT; cfg_data = '0;
        src_idle = 0; dst_idle = 0; n_req = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: extremes, duplicates, store full, table full
        send(MODE_LOOKUP, 64'd0, 64'd0);
        send(MODE_INSERT, 64'd0, '1);
        send(MODE_INSERT, '1, 64'd0);
        send(MODE_INSERT, 64'h8080808080808080, 64'h0123456789abcdef);
        send(MODE_INSERT, 64'd0, 64'd5);
        send(MODE_LOOKUP, 64'd0, 64'd0);
        send(MODE_LOOKUP, '1, '1);
        send(MODE_LOOKUP, 64'h8080808080808080, 64'd0);
        send(MODE_LOOKUP, 64'h7f7f7f7f7f7f7f7f, 64'd0);
        drain();
        write_reg(REG_BUCKET_COUNT, 32'd3);
        write_reg(REG_KEY_BYTES, 32'd1);
        write_reg(REG_VALUE_BYTES, 32'd1);
        for (int i = 0; i < 4; i++) send(MODE_INSERT, 64'hff00 + i, 64'h1234);
        send(MODE_LOOKUP, 64'h12ff, 64'd0);
        send(MODE_LOOKUP, 64'h55, 64'd0);
        drain();
        write_reg(REG_ITEM_CAPACITY, 32'd0);
        send(MODE_INSERT, 64'd9, 64'd9);
        drain();
        write_reg(REG_BUCKET_COUNT, 32'd0);
        write_reg(REG_KEY_BYTES, 32'd15);
        write_reg(REG_VALUE_BYTES, 32'd0);
        write_reg(REG_ITEM_CAPACITY, 32'd511);
        send(MODE_INSERT, 64'd1, 64'hffff);
        send(MODE_LOOKUP, 64'd1, 64'd0);
        drain();
        write_reg(REG_BUCKET_COUNT, 32'd1023);
        write_reg(REG_VALUE_BYTES, 32'd15);

        src_idle = 7; dst_idle = 48;
        random_phase(240);
        drain();
        write_reg(REG_KEY_BYTES, 32'd2);
        write_reg(REG_VALUE_BYTES, 32'd3);
        src_idle = 48; dst_idle = 7;
        random_phase(350);
        drain();
        write_reg(REG_BUCKET_COUNT, 32'd64);
        write_reg(REG_KEY_BYTES, 32'd8);
        src_idle = 0; dst_idle = 0;
        random_phase(400);
        drain();
        write_reg(REG_BUCKET_COUNT, 32'd512);
        write_reg(REG_VALUE_BYTES, 32'd8);
        random_phase(400);
        drain();

        $display("%0d requests: %0d hits, %0d misses, %0d store full, %0d no bucket",
                 n_req, sb.n_hits, sb.n_miss, sb.n_full, sb.n_nobkt);
        if (sb.errors == 0 && sb.exp_status.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
